// File: rtl/stepped_dose_controller_defines.svh
// ----------------------------------------------------------------------------
// Stepped dose controller assertion macros
// Shared property macros for the checker of the dosing controller.
// ----------------------------------------------------------------------------
`ifndef STEPPED_DOSE_CONTROLLER_DEFINES_SVH
`define STEPPED_DOSE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stepped dose controller check failed");

// Next-cycle implication, disabled while reset is high.
`define SDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stepped dose controller check failed");

`endif

// File: rtl/sdc_pkg.sv
// ----------------------------------------------------------------------------
// Stepped dose controller package
// Types, codes and timing constants shared by the dosing controller modules.
// ----------------------------------------------------------------------------
package sdc_pkg;

   localparam int CYCLE_SECONDS = 600;
   localparam int TICK_SECONDS  = 10;
   localparam int LIMIT_SCALE   = 60;

   localparam int LIMIT_W = 16 + $clog2(LIMIT_SCALE);
   localparam int DOSE_W  = 16 + $clog2(TICK_SECONDS + 1);

   localparam logic [15:0] ON_TICKS_20   = 16'(((CYCLE_SECONDS * 20) / 100) / TICK_SECONDS);
   localparam logic [15:0] OFF_TICKS_20  = 16'(((CYCLE_SECONDS * 80) / 100) / TICK_SECONDS);
   localparam logic [15:0] ON_TICKS_50   = 16'(((CYCLE_SECONDS * 50) / 100) / TICK_SECONDS);
   localparam logic [15:0] OFF_TICKS_50  = 16'(((CYCLE_SECONDS * 50) / 100) / TICK_SECONDS);
   localparam logic [15:0] ON_TICKS_75   = 16'(((CYCLE_SECONDS * 75) / 100) / TICK_SECONDS);
   localparam logic [15:0] OFF_TICKS_75  = 16'(((CYCLE_SECONDS * 25) / 100) / TICK_SECONDS);
   localparam logic [15:0] ON_TICKS_100  = 16'(((CYCLE_SECONDS * 100) / 100) / TICK_SECONDS);
   localparam logic [15:0] OFF_TICKS_100 = 16'(((CYCLE_SECONDS * 0) / 100) / TICK_SECONDS);

   localparam logic signed [11:0] TARGET_RESET = 12'sd700;
   localparam logic [9:0]         STEP_RESET   = 10'd50;
   localparam logic [15:0]        LIMIT_RESET  = 16'd1000;
   localparam logic [15:0]        FLOW_RESET   = 16'd25;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_SET_MODE = 2'd1,
      OP_CLEAR    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_AUTO   = 2'd1,
      MODE_FORCED = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ON    = 2'd1,
      PH_PAUSE = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      STEP_NONE = 3'd0,
      STEP_20   = 3'd1,
      STEP_50   = 3'd2,
      STEP_75   = 3'd3,
      STEP_100  = 3'd4
   } step_type;

   typedef enum logic [1:0] {
      REG_TARGET = 2'd0,
      REG_STEP   = 2'd1,
      REG_LIMIT  = 2'd2,
      REG_FLOW   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [11:0] target;
      logic [9:0]         width1;
      logic [10:0]        width2;
      logic [11:0]        width3;
      logic [LIMIT_W-1:0] limit_units;
      logic [DOSE_W-1:0]  dose_units;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [11:0] measured_level;
      logic [1:0]         new_mode;
      logic               ph_idle;
      logic               filtration_auto;
      logic               filter_pump_on;
      logic               level_ok;
      logic               filter_active;
   } item_type;

   typedef struct packed {
      logic               limit_alarm;
      logic [2:0]         step_started;
      logic [31:0]        daily_total;
      logic [1:0]         phase;
      logic [1:0]         mode_now;
      logic               pump_on;
   } res_type;

endpackage

// File: rtl/sdc_csr.sv
// ----------------------------------------------------------------------------
// Stepped dose controller configuration registers
// Holds the settings and keeps them pre-scaled for the update logic.
// ----------------------------------------------------------------------------
module sdc_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output sdc_pkg::cfg_type    cfg
);

   sdc_pkg::cfg_type cfg_ff;
   sdc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (sdc_pkg::reg_index_type'(csr_index))
            sdc_pkg::REG_TARGET: begin
               cfg_in.target = $signed(csr_wdata[11:0]);
            end
            sdc_pkg::REG_STEP: begin
               cfg_in.width1 = csr_wdata[9:0];
               cfg_in.width2 = {csr_wdata[9:0], 1'b0};
               cfg_in.width3 = 12'(csr_wdata[9:0]) * 12'd3;
            end
            sdc_pkg::REG_LIMIT: begin
               cfg_in.limit_units = sdc_pkg::LIMIT_W'(csr_wdata) *
                                    sdc_pkg::LIMIT_W'(sdc_pkg::LIMIT_SCALE);
            end
            sdc_pkg::REG_FLOW: begin
               cfg_in.dose_units = sdc_pkg::DOSE_W'(csr_wdata) *
                                   sdc_pkg::DOSE_W'(sdc_pkg::TICK_SECONDS);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target      <= sdc_pkg::TARGET_RESET;
         cfg_ff.width1      <= sdc_pkg::STEP_RESET;
         cfg_ff.width2      <= {sdc_pkg::STEP_RESET, 1'b0};
         cfg_ff.width3      <= 12'(sdc_pkg::STEP_RESET) * 12'd3;
         cfg_ff.limit_units <= sdc_pkg::LIMIT_W'(sdc_pkg::LIMIT_RESET) *
                               sdc_pkg::LIMIT_W'(sdc_pkg::LIMIT_SCALE);
         cfg_ff.dose_units  <= sdc_pkg::DOSE_W'(sdc_pkg::FLOW_RESET) *
                               sdc_pkg::DOSE_W'(sdc_pkg::TICK_SECONDS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/sdc_ctrl.sv
// ----------------------------------------------------------------------------
// Stepped dose controller state update
// Holds mode, phase, pump, tick counters and daily total, and computes the
// next state and the result for the item in the input register.
// ----------------------------------------------------------------------------
module sdc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  sdc_pkg::item_type   item,
   input  sdc_pkg::cfg_type    cfg,
   output sdc_pkg::res_type    res
);

   sdc_pkg::mode_type  mode_ff,  mode_in;
   sdc_pkg::phase_type phase_ff, phase_in;
   logic               pump_ff,  pump_in;
   logic [15:0]        on_left_ff,  on_left_in;
   logic [15:0]        off_left_ff, off_left_in;
   logic [31:0]        acc_ff,   acc_in;

   logic               ok;
   logic               over_now;
   logic               over_added;
   logic [32:0]        sum;
   logic [31:0]        added;
   logic signed [12:0] err;
   sdc_pkg::step_type  step;
   sdc_pkg::step_type  step_sel;
   logic               alarm;

   always_comb begin
      ok = item.ph_idle && (mode_ff == sdc_pkg::MODE_AUTO) && item.filtration_auto &&
           item.filter_pump_on && item.level_ok && item.filter_active;
      over_now   = acc_ff > 32'(cfg.limit_units);
      sum        = {1'b0, acc_ff} + 33'(cfg.dose_units);
      added      = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      over_added = added > 32'(cfg.limit_units);
      err        = 13'(cfg.target) - 13'(item.measured_level);

      if (err > $signed({1'b0, cfg.width3})) begin
         step_sel = sdc_pkg::STEP_100;
      end else if (err > $signed({2'b0, cfg.width2})) begin
         step_sel = sdc_pkg::STEP_75;
      end else if (err > $signed({3'b0, cfg.width1})) begin
         step_sel = sdc_pkg::STEP_50;
      end else if (err > 13'sd0) begin
         step_sel = sdc_pkg::STEP_20;
      end else begin
         step_sel = sdc_pkg::STEP_NONE;
      end

      mode_in     = mode_ff;
      phase_in    = phase_ff;
      pump_in     = pump_ff;
      on_left_in  = on_left_ff;
      off_left_in = off_left_ff;
      acc_in      = acc_ff;
      step        = sdc_pkg::STEP_NONE;
      alarm       = 1'b0;

      case (sdc_pkg::op_type'(item.operation))
         sdc_pkg::OP_TICK: begin
            case (phase_ff)
               sdc_pkg::PH_IDLE: begin
                  if (ok && !over_now) begin
                     step = step_sel;
                     case (step_sel)
                        sdc_pkg::STEP_20: begin
                           on_left_in  = sdc_pkg::ON_TICKS_20;
                           off_left_in = sdc_pkg::OFF_TICKS_20;
                        end
                        sdc_pkg::STEP_50: begin
                           on_left_in  = sdc_pkg::ON_TICKS_50;
                           off_left_in = sdc_pkg::OFF_TICKS_50;
                        end
                        sdc_pkg::STEP_75: begin
                           on_left_in  = sdc_pkg::ON_TICKS_75;
                           off_left_in = sdc_pkg::OFF_TICKS_75;
                        end
                        default: begin
                           on_left_in  = sdc_pkg::ON_TICKS_100;
                           off_left_in = sdc_pkg::OFF_TICKS_100;
                        end
                     endcase
                     if (step_sel == sdc_pkg::STEP_NONE) begin
                        on_left_in  = on_left_ff;
                        off_left_in = off_left_ff;
                     end else begin
                        phase_in = sdc_pkg::PH_ON;
                        pump_in  = 1'b1;
                     end
                  end else if (mode_ff == sdc_pkg::MODE_FORCED) begin
                     acc_in = added;
                     if (over_added) begin
                        mode_in = sdc_pkg::MODE_OFF;
                        pump_in = 1'b0;
                        alarm   = 1'b1;
                     end
                  end
               end
               sdc_pkg::PH_ON: begin
                  acc_in = added;
                  if (on_left_ff <= 16'd1) begin
                     on_left_in = '0;
                     phase_in   = sdc_pkg::PH_PAUSE;
                     pump_in    = 1'b0;
                  end else begin
                     on_left_in = on_left_ff - 16'd1;
                  end
                  if (!(ok && !over_added)) begin
                     phase_in = sdc_pkg::PH_IDLE;
                     pump_in  = 1'b0;
                  end
               end
               sdc_pkg::PH_PAUSE: begin
                  if (off_left_ff <= 16'd1) begin
                     off_left_in = '0;
                     phase_in    = sdc_pkg::PH_IDLE;
                  end else begin
                     off_left_in = off_left_ff - 16'd1;
                  end
                  if (!(ok && !over_now)) begin
                     phase_in = sdc_pkg::PH_IDLE;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         sdc_pkg::OP_SET_MODE: begin
            case (sdc_pkg::mode_type'(item.new_mode))
               sdc_pkg::MODE_OFF: begin
                  mode_in = sdc_pkg::MODE_OFF;
                  pump_in = 1'b0;
               end
               sdc_pkg::MODE_AUTO: begin
                  if (mode_ff != sdc_pkg::MODE_AUTO) begin
                     mode_in  = sdc_pkg::MODE_AUTO;
                     phase_in = sdc_pkg::PH_IDLE;
                  end
               end
               sdc_pkg::MODE_FORCED: begin
                  mode_in = sdc_pkg::MODE_FORCED;
                  pump_in = 1'b1;
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
         sdc_pkg::OP_CLEAR: begin
            acc_in = '0;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase

      res.pump_on      = pump_in;
      res.mode_now     = mode_in;
      res.phase        = phase_in;
      res.daily_total  = acc_in;
      res.step_started = step;
      res.limit_alarm  = alarm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= sdc_pkg::MODE_OFF;
         phase_ff    <= sdc_pkg::PH_IDLE;
         pump_ff     <= 1'b0;
         on_left_ff  <= '0;
         off_left_ff <= '0;
         acc_ff      <= '0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         phase_ff    <= phase_in;
         pump_ff     <= pump_in;
         on_left_ff  <= on_left_in;
         off_left_ff <= off_left_in;
         acc_ff      <= acc_in;
      end
   end

endmodule

// File: rtl/stepped_dose_controller.sv
// ----------------------------------------------------------------------------
// Stepped dose controller
// Redox dosing pump regulator with stepped duty cycles and a daily limit.
// ----------------------------------------------------------------------------
// The block takes one item per clock while results are not stalled and returns
// exactly one result per item: the item is captured in an input register, the
// state update runs in one pass of logic, and the result lands in an output
// register. The result register decouples the sides, so a new item is taken
// into an empty input register while a finished result waits. Settings are to
// be written through the csr port while no item is in flight (the block does
// not enforce this) and take effect at once; no startup sweep after reset.
module stepped_dose_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // measured_level[11:0], new_mode[13:12], ph_idle[14], filtration_auto[15],
   // filter_pump_on[16], level_ok[17], filter_active[18], zero fill above.
   input  logic [23:0] req_tdata,
   // operation[1:0].
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pump_on[0], mode_now[2:1], phase[4:3], daily_total[36:5],
   // step_started[39:37], limit_alarm[40], zero fill above.
   output logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   sdc_pkg::cfg_type  cfg;
   sdc_pkg::item_type item_ff;
   sdc_pkg::res_type  res;
   sdc_pkg::res_type  res_ff;
   logic              item_valid_ff;
   logic              rsp_valid_ff;
   logic              out_free;
   logic              fire;
   logic              take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = item_valid_ff && out_free;
   assign req_tready = !item_valid_ff || out_free;
   assign take       = req_tvalid && req_tready;

   sdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item_ff),
      .cfg   (cfg),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            item_valid_ff <= 1'b1;
         end else if (fire) begin
            item_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.operation       <= req_tuser;
         item_ff.measured_level  <= $signed(req_tdata[11:0]);
         item_ff.new_mode        <= req_tdata[13:12];
         item_ff.ph_idle         <= req_tdata[14];
         item_ff.filtration_auto <= req_tdata[15];
         item_ff.filter_pump_on  <= req_tdata[16];
         item_ff.level_ok        <= req_tdata[17];
         item_ff.filter_active   <= req_tdata[18];
      end
      if (fire) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, res_ff.limit_alarm, res_ff.step_started,
                        res_ff.daily_total, res_ff.phase, res_ff.mode_now,
                        res_ff.pump_on};

endmodule

// File: rtl/sdc_checker.sv
// ----------------------------------------------------------------------------
// Stepped dose controller checker
// Port-level properties of the dosing controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "stepped_dose_controller_defines.svh"

module sdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   logic       pump_on;
   logic [1:0] mode_now;
   logic [1:0] phase;
   logic [2:0] step_started;
   logic       limit_alarm;
   logic       rsp_wait;
   logic       off_shown;
   logic       alarm_shown;
   logic       alarm_state_ok;
   logic       step_shown;
   logic       step_state_ok;

   assign pump_on        = rsp_tdata[0];
   assign mode_now       = rsp_tdata[2:1];
   assign phase          = rsp_tdata[4:3];
   assign step_started   = rsp_tdata[39:37];
   assign limit_alarm    = rsp_tdata[40];
   assign rsp_wait       = rsp_tvalid && !rsp_tready;
   assign off_shown      = rsp_tvalid && (mode_now == sdc_pkg::MODE_OFF);
   assign alarm_shown    = rsp_tvalid && limit_alarm;
   assign alarm_state_ok = (mode_now == sdc_pkg::MODE_OFF) &&
                           (step_started == sdc_pkg::STEP_NONE);
   assign step_shown     = rsp_tvalid && (step_started != sdc_pkg::STEP_NONE);
   assign step_state_ok  = (phase == sdc_pkg::PH_ON) && pump_on;

   `SDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_tdata))
   `SDC_ASSERT_IMPL(a_off_no_pump, clock, reset, off_shown, !pump_on)
   `SDC_ASSERT_IMPL(a_alarm_off, clock, reset, alarm_shown, alarm_state_ok)
   `SDC_ASSERT_IMPL(a_step_starts_on, clock, reset, step_shown, step_state_ok)
   `SDC_ASSERT_IMPL(a_empty_after_reset, clock, reset, $past(reset), !rsp_tvalid)

endmodule

bind stepped_dose_controller sdc_checker u_sdc_checker (.*);
